// ----- rtl/stl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token codes and keyword tables of the token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned PositionBitsDefault = 16;
  localparam int unsigned KwCount = 19;
  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_IDENT = 3'd1,
    M_INT   = 3'd2,
    M_FRAC  = 3'd3,
    M_STR   = 3'd4,
    M_ESC   = 3'd5,
    M_OP    = 3'd6
  } mode_e;

  localparam logic [5:0] K_BOOLEAN = 6'd17;
  localparam logic [5:0] K_ERROR   = 6'd18;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_ARROW   = 6'd22;
  localparam logic [5:0] K_LBRACE  = 6'd23;
  localparam logic [5:0] K_RBRACE  = 6'd24;
  localparam logic [5:0] K_EOF     = 6'd25;
  localparam logic [5:0] K_LPAREN  = 6'd26;
  localparam logic [5:0] K_RPAREN  = 6'd27;
  localparam logic [5:0] K_LBRACK  = 6'd28;
  localparam logic [5:0] K_RBRACK  = 6'd29;
  localparam logic [5:0] K_COMMA   = 6'd30;
  localparam logic [5:0] K_DOT     = 6'd31;
  localparam logic [5:0] K_SEMI    = 6'd32;
  localparam logic [5:0] K_COLON   = 6'd33;
  localparam logic [5:0] K_PLUS    = 6'd34;
  localparam logic [5:0] K_MINUS   = 6'd35;
  localparam logic [5:0] K_STAR    = 6'd36;
  localparam logic [5:0] K_SLASH   = 6'd37;
  localparam logic [5:0] K_EQ      = 6'd38;
  localparam logic [5:0] K_ASSIGN  = 6'd39;
  localparam logic [5:0] K_NEQ     = 6'd40;
  localparam logic [5:0] K_NOT     = 6'd41;
  localparam logic [5:0] K_LTE     = 6'd42;
  localparam logic [5:0] K_LT      = 6'd43;
  localparam logic [5:0] K_GTE     = 6'd44;
  localparam logic [5:0] K_GT      = 6'd45;
  localparam logic [5:0] K_AND     = 6'd46;
  localparam logic [5:0] K_OR      = 6'd47;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [30:0] value;
    logic        point_seen;
    logic        bool_val;
    logic [7:0]  err_byte;
  } token_t;

  function automatic logic [3:0] kw_len(input int unsigned k);
    logic [3:0] r;
    begin
      unique case (k)
        0: r = 4'd4;   1: r = 4'd3;   2: r = 4'd3;   3: r = 4'd5;
        4: r = 4'd5;   5: r = 4'd6;   6: r = 4'd2;   7: r = 4'd4;
        8: r = 4'd3;   9: r = 4'd5;   10: r = 4'd7;  11: r = 4'd6;
        12: r = 4'd6;  13: r = 4'd3;  14: r = 4'd7;  15: r = 4'd9;
        16: r = 4'd8;  17: r = 4'd4;  18: r = 4'd5;
        default: r = 4'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [71:0] kw_text(input int unsigned k);
    logic [71:0] r;
    begin
      unique case (k)
        0: r = "with";      1: r = "var";       2: r = "new";
        3: r = "async";     4: r = "await";     5: r = "return";
        6: r = "if";        7: r = "else";      8: r = "for";
        9: r = "while";     10: r = "attempt";  11: r = "rescue";
        12: r = "shared";   13: r = "pub";      14: r = "private";
        15: r = "protected"; 16: r = "internal"; 17: r = "true";
        default: r = "false";
      endcase
      return r;
    end
  endfunction

  // character at position pos of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned pos);
    logic [71:0] t;
    logic [3:0]  l;
    begin
      t = kw_text(k);
      l = kw_len(k);
      if (pos >= 32'(l)) return 8'd0;
      return t[8*(32'(l)-1-pos) +: 8];
    end
  endfunction

  function automatic token_t tok(input logic [5:0] kind, input logic [1:0] err,
                                 input logic [15:0] line, input logic [15:0] col,
                                 input logic [15:0] len, input logic [30:0] val,
                                 input logic isf, input logic bv,
                                 input logic [7:0] eb);
    token_t t;
    begin
      t.kind = kind; t.err = err; t.line = line; t.column = col;
      t.length = len; t.value = val; t.point_seen = isf; t.bool_val = bv;
      t.err_byte = eb;
      return t;
    end
  endfunction

endpackage

// ----- rtl/stl_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_scan
// Scanner state and one-byte step: emits up to two tokens per byte.
// ----------------------------------------------------------------------------
module stl_scan #(
  parameter int unsigned PositionBits = stl_pkg::PositionBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            end_i,
  output logic [1:0]      count_o,
  output stl_pkg::token_t tok0_o,
  output stl_pkg::token_t tok1_o
);
  import stl_pkg::*;

  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam logic [PositionBits-1:0] PosOne = PositionBits'(1);

  mode_e                   mode_q, mode_d;
  logic [KwCount-1:0]      kw_q, kw_d;
  logic [PositionBits-1:0] len_q, len_d, scol_q, scol_d, line_q, line_d;
  logic [PositionBits-1:0] col_q, col_d;
  logic [30:0]             acc_q, acc_d;
  logic [7:0]              op_q, op_d;
  logic                    sq_q, sq_d;

  function automatic logic [15:0] sat(input logic [PositionBits-1:0] v);
    if (PositionBits > 16 && v > PositionBits'(16'hFFFF)) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [PositionBits-1:0] inc(input logic [PositionBits-1:0] v);
    return (v != PosMax) ? v + PosOne : v;
  endfunction

  function automatic logic [KwCount-1:0] match(input logic [KwCount-1:0] m,
                                               input logic [PositionBits-1:0] l,
                                               input logic [7:0] b);
    logic [KwCount-1:0] r;
    begin
      r = m;
      for (int k = 0; k < KwCount; k++) begin
        if (l >= PositionBits'(kw_len(k)) || kw_char(k, 32'(l[3:0])) != b) r[k] = 1'b0;
      end
      return r;
    end
  endfunction

  logic       is_alpha, is_digit, is_word;
  logic [5:0] single_k, pair_k;
  logic [34:0] mul10;

  assign is_alpha = (byte_i >= "a" && byte_i <= "z") || (byte_i >= "A" && byte_i <= "Z");
  assign is_digit = byte_i >= "0" && byte_i <= "9";
  assign is_word  = is_alpha || is_digit || byte_i == "_";
  assign mul10    = {4'b0, acc_q} * 35'd10 + 35'(byte_i - "0");

  always_comb begin
    single_k = 6'd0;
    unique case (byte_i)
      "(": single_k = K_LPAREN;  ")": single_k = K_RPAREN;
      "{": single_k = K_LBRACE;  "}": single_k = K_RBRACE;
      "[": single_k = K_LBRACK;  "]": single_k = K_RBRACK;
      ",": single_k = K_COMMA;   ".": single_k = K_DOT;
      ";": single_k = K_SEMI;    ":": single_k = K_COLON;
      "+": single_k = K_PLUS;    "*": single_k = K_STAR;
      "/": single_k = K_SLASH;
      default: single_k = 6'd0;
    endcase
    pair_k = 6'd0;
    if (op_q == "-" && byte_i == ">") pair_k = K_ARROW;
    if (op_q == "=" && byte_i == "=") pair_k = K_EQ;
    if (op_q == "!" && byte_i == "=") pair_k = K_NEQ;
    if (op_q == "<" && byte_i == "=") pair_k = K_LTE;
    if (op_q == ">" && byte_i == "=") pair_k = K_GTE;
    if (op_q == "&" && byte_i == "&") pair_k = K_AND;
    if (op_q == "|" && byte_i == "|") pair_k = K_OR;
  end

  always_comb begin
    token_t ft;
    logic   fl, restart;
    logic [5:0] k;
    logic   bv;
    mode_d = mode_q; kw_d = kw_q; len_d = len_q; scol_d = scol_q;
    line_d = line_q; col_d = col_q; acc_d = acc_q; op_d = op_q; sq_d = sq_q;
    count_o = 2'd0;
    tok0_o = '0;
    tok1_o = '0;
    ft = '0;
    fl = 1'b0;
    restart = 1'b0;
    k = K_IDENT;
    bv = 1'b0;
    // pending token of the current mode
    for (int i = 0; i < KwCount; i++) begin
      if (kw_q[i] && PositionBits'(kw_len(i)) == len_q) begin
        k = (i < 17) ? 6'(i) : K_BOOLEAN;
        bv = (i == 17);
      end
    end
    unique case (mode_q)
      M_IDENT: begin
        fl = 1'b1;
        ft = tok(k, ERR_NONE, sat(line_q), sat(scol_q), sat(len_q), '0, 1'b0, bv, 8'd0);
      end
      M_INT, M_FRAC: begin
        fl = 1'b1;
        ft = tok(K_NUMBER, ERR_NONE, sat(line_q), sat(scol_q), sat(len_q), acc_q,
                 mode_q == M_FRAC, 1'b0, 8'd0);
      end
      M_OP: begin
        fl = 1'b1;
        unique case (op_q)
          "-": ft = tok(K_MINUS, ERR_NONE, sat(line_q), sat(scol_q), 16'd1, '0, 1'b0, 1'b0, 8'd0);
          "=": ft = tok(K_ASSIGN, ERR_NONE, sat(line_q), sat(scol_q), 16'd1, '0, 1'b0, 1'b0, 8'd0);
          "!": ft = tok(K_NOT, ERR_NONE, sat(line_q), sat(scol_q), 16'd1, '0, 1'b0, 1'b0, 8'd0);
          "<": ft = tok(K_LT, ERR_NONE, sat(line_q), sat(scol_q), 16'd1, '0, 1'b0, 1'b0, 8'd0);
          ">": ft = tok(K_GT, ERR_NONE, sat(line_q), sat(scol_q), 16'd1, '0, 1'b0, 1'b0, 8'd0);
          default: ft = tok(K_ERROR, ERR_CHAR, sat(line_q), sat(scol_q), 16'd1, '0, 1'b0, 1'b0, op_q);
        endcase
      end
      M_STR, M_ESC: begin
        fl = 1'b1;
        ft = tok(K_ERROR, ERR_STRING, sat(line_q), sat(scol_q), sat(len_q), '0, 1'b0, 1'b0, 8'd0);
      end
      default: fl = 1'b0;
    endcase

    if (end_i || byte_i == 8'd0) begin
      token_t eof;
      eof = tok(K_EOF, ERR_NONE, sat(line_q), sat(col_q > PosOne ? col_q - PosOne : PosOne),
                16'd0, '0, 1'b0, 1'b0, 8'd0);
      if (fl) begin
        tok0_o = ft; tok1_o = eof; count_o = 2'd2;
      end else begin
        tok0_o = eof; count_o = 2'd1;
      end
      mode_d = M_IDLE; kw_d = '1; len_d = '0; scol_d = PosOne; line_d = PosOne;
      col_d = PosOne; acc_d = '0; op_d = 8'd0; sq_d = 1'b0;
    end else begin
      unique case (mode_q)
        M_IDENT: begin
          if (is_word) begin
            kw_d = match(kw_q, len_q, byte_i);
            len_d = inc(len_q); col_d = inc(col_q);
          end else begin
            tok0_o = ft; count_o = 2'd1; restart = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (is_digit || (byte_i == "." && mode_q == M_INT)) begin
            if (byte_i == ".") mode_d = M_FRAC;
            else if (mode_q == M_INT) acc_d = (mul10 > 35'(NumMax)) ? NumMax : mul10[30:0];
            len_d = inc(len_q); col_d = inc(col_q);
          end else begin
            tok0_o = ft; count_o = 2'd1; restart = 1'b1;
          end
        end
        M_STR: begin
          col_d = inc(col_q);
          if (byte_i == (sq_q ? 8'h27 : 8'h22)) begin
            tok0_o = tok(K_STRING, ERR_NONE, sat(line_q), sat(scol_q), sat(len_q), '0,
                         1'b0, 1'b0, 8'd0);
            count_o = 2'd1; mode_d = M_IDLE;
          end else begin
            if (byte_i == "\\") mode_d = M_ESC;
            len_d = inc(len_q);
          end
        end
        M_ESC: begin
          col_d = inc(col_q); len_d = inc(len_q); mode_d = M_STR;
        end
        M_OP: begin
          if (pair_k != 6'd0) begin
            col_d = inc(col_q);
            tok0_o = tok(pair_k, ERR_NONE, sat(line_q), sat(scol_q), 16'd2, '0, 1'b0, 1'b0, 8'd0);
            count_o = 2'd1; mode_d = M_IDLE; op_d = 8'd0;
          end else begin
            tok0_o = ft; count_o = 2'd1; restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        token_t st;
        logic   emit;
        mode_d = M_IDLE;
        if (mode_q == M_OP) op_d = 8'd0;
        emit = 1'b0;
        st = '0;
        if (byte_i == " " || byte_i == 8'h09 || byte_i == 8'h0D) begin
          col_d = inc(col_q);
        end else if (byte_i == 8'h0A) begin
          line_d = inc(line_q); col_d = PosOne;
        end else begin
          scol_d = col_q; col_d = inc(col_q);
          if (is_alpha || byte_i == "_") begin
            mode_d = M_IDENT; kw_d = match('1, '0, byte_i); len_d = PosOne;
          end else if (is_digit) begin
            mode_d = M_INT; len_d = PosOne; acc_d = 31'(byte_i - "0");
          end else if (byte_i == 8'h22 || byte_i == 8'h27) begin
            mode_d = M_STR; sq_d = (byte_i == 8'h27); len_d = '0;
          end else if (byte_i == "-" || byte_i == "=" || byte_i == "!" || byte_i == "<" ||
                       byte_i == ">" || byte_i == "&" || byte_i == "|") begin
            mode_d = M_OP; op_d = byte_i;
          end else begin
            emit = 1'b1;
            if (single_k != 6'd0)
              st = tok(single_k, ERR_NONE, sat(line_q), sat(col_q), 16'd1, '0, 1'b0, 1'b0, 8'd0);
            else
              st = tok(K_ERROR, ERR_CHAR, sat(line_q), sat(col_q), 16'd1, '0, 1'b0, 1'b0, byte_i);
          end
        end
        if (emit) begin
          if (count_o == 2'd1) begin
            tok1_o = st; count_o = 2'd2;
          end else begin
            tok0_o = st; count_o = 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; kw_q <= '1; len_q <= '0; scol_q <= PosOne; line_q <= PosOne;
      col_q <= PosOne; acc_q <= '0; op_q <= 8'd0; sq_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; kw_q <= kw_d; len_q <= len_d; scol_q <= scol_d; line_q <= line_d;
      col_q <= col_d; acc_q <= acc_d; op_q <= op_d; sq_q <= sq_d;
    end
  end

endmodule

// ----- rtl/stl_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_outq
// Four-entry token queue between the scanner and the output channel.
// ----------------------------------------------------------------------------
module stl_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      count_i,
  input  stl_pkg::token_t tok0_i,
  input  stl_pkg::token_t tok1_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            stall_i,
  output stl_pkg::token_t tok_o,
  output logic            last_o
);
  import stl_pkg::*;

  token_t     mem_q [4];
  logic       last_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 3'd0;
  assign pop     = valid_o && !stall_i;
  // staged tokens still count against the free slots
  assign room_o  = (cnt_q + 3'(count_i)) <= 3'd2;
  assign tok_o   = mem_q[rp_q];
  assign last_o  = last_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (count_i != 2'd0) begin
      mem_q[wp_q]  <= tok0_i;
      last_q[wp_q] <= count_i == 2'd1;
    end
    if (count_i == 2'd2) begin
      mem_q[wp_q + 2'd1]  <= tok1_i;
      last_q[wp_q + 2'd1] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + count_i;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(count_i) - 3'(pop);
    end
  end

endmodule

// ----- rtl/source_token_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming lexer: one source byte per request, tokens out.
// ----------------------------------------------------------------------------
//  channel | signals                              | dir
//  in      | in_valid_i in_stall_o byte/end       | request in
//  out     | out_valid_o out_stall_i token fields | tokens out
// One byte per cycle while in_stall_o is low; scanner state updates on the accept edge.
// Tokens pass a staging register, then enter a four-entry queue; 0 to 2 per byte.
// A token passes the staging register and the queue before it is offered.
// Input stalls while queued plus staged tokens exceed two.
// Reset returns to line 1, column 1, idle between tokens.
module source_token_lexer #(
  parameter int unsigned PositionBits = stl_pkg::PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [1:0]  error_kind_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic [15:0] token_length_o,
  output logic [30:0] number_value_o,
  output logic        number_has_point_o,
  output logic        truth_value_o,
  output logic [7:0]  error_byte_o,
  output logic        last_of_run_o
);
  import stl_pkg::*;

  logic       step, room;
  logic [1:0] cnt, cnt_q;
  token_t     t0, t1, t0_q, t1_q, tq;

  assign in_stall_o = !room;
  assign step = in_valid_i && !in_stall_o;

  stl_scan #(.PositionBits(PositionBits)) u_scan (
    .clk_i, .rst_ni, .step_i(step), .byte_i(byte_value_i), .end_i(end_of_input_i),
    .count_o(cnt), .tok0_o(t0), .tok1_o(t1)
  );

  always_ff @(posedge clk_i) begin
    t0_q <= t0;
    t1_q <= t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= step ? cnt : 2'd0;
  end

  stl_outq u_q (
    .clk_i, .rst_ni, .count_i(cnt_q), .tok0_i(t0_q), .tok1_i(t1_q),
    .room_o(room), .valid_o(out_valid_o), .stall_i(out_stall_i),
    .tok_o(tq), .last_o(last_of_run_o)
  );

  assign token_kind_o       = tq.kind;
  assign error_kind_o       = tq.err;
  assign token_line_o       = tq.line;
  assign token_column_o     = tq.column;
  assign token_length_o     = tq.length;
  assign number_value_o     = tq.value;
  assign number_has_point_o = tq.point_seen;
  assign truth_value_o      = tq.bool_val;
  assign error_byte_o       = tq.err_byte;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad token count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == K_EOF |-> last_of_run_o) else $error("EOF not last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == K_ERROR |-> error_kind_o != ERR_NONE)
    else $error("error token without kind");

endmodule
